[hw/rtl/thmadc_pkg.sv]
// Shared types and constants for the thermistor ADC to temperature converter.
// Holds the calibration table, status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package thmadc_pkg;

    localparam int BUILTIN_ENTRIES = 21;
    localparam int PT_W            = 10;  // width of a calibration point
    localparam int IDX_W           = 5;   // table index, 0..BUILTIN_ENTRIES
    localparam int DIFF_W          = 7;   // span between neighbors, < 128
    localparam int NUM_W           = 12;  // (hi - sample) * 50 < 4096
    localparam int QUOT_W          = 6;   // quotient < 50
    localparam int STEP_W          = 3;
    localparam int TEMP_W          = 11;
    localparam int STATUS_W        = 2;
    localparam int STEP_DECI       = 50;
    localparam int OFFSET_DECI     = 150;

    localparam logic [STEP_W-1:0] SEARCH_LAST = STEP_W'(IDX_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(QUOT_W - 1);

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SETUP,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              search;
        logic              setup;
        logic              divide;
        logic              finish;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic out_free;
    } t_dp_sts;

    // Ascending calibration points, -15 C to 85 C in 5 C steps.
    function automatic logic [PT_W-1:0] cal_point(input logic [IDX_W-1:0] i);
        logic [PT_W-1:0] v;
        case (i)
            5'd0:    v = 10'd144;
            5'd1:    v = 10'd184;
            5'd2:    v = 10'd231;
            5'd3:    v = 10'd283;
            5'd4:    v = 10'd340;
            5'd5:    v = 10'd401;
            5'd6:    v = 10'd462;
            5'd7:    v = 10'd523;
            5'd8:    v = 10'd582;
            5'd9:    v = 10'd638;
            5'd10:   v = 10'd688;
            5'd11:   v = 10'd734;
            5'd12:   v = 10'd774;
            5'd13:   v = 10'd809;
            5'd14:   v = 10'd839;
            5'd15:   v = 10'd864;
            5'd16:   v = 10'd886;
            5'd17:   v = 10'd905;
            5'd18:   v = 10'd920;
            5'd19:   v = 10'd933;
            5'd20:   v = 10'd944;
            default: v = 10'd1023;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/thmadc_in_if.sv]
// Sample channel: valid/ready handshake carrying one raw ADC sample.
// No dependencies.
interface thmadc_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

[hw/rtl/thmadc_out_if.sv]
// Result channel: valid/ready handshake carrying status and temperature.
// No dependencies.
interface thmadc_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic signed [10:0] temperature_deci;

    modport source (output valid, output status, output temperature_deci, input ready);
    modport sink   (input valid, input status, input temperature_deci, output ready);
endinterface

[hw/rtl/thmadc_ctrl.sv]
// Controller FSM: sequences table search, divide setup, quotient loop and
// result hand-off. Depends on thmadc_pkg.
module thmadc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  thmadc_pkg::t_dp_sts  i_sts,
    output thmadc_pkg::t_dp_cmd  o_cmd
);

    thmadc_pkg::t_state                r_state, n_state;
    logic [thmadc_pkg::STEP_W-1:0]     r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thmadc_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            thmadc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = thmadc_pkg::ST_SEARCH;
                    n_step  = thmadc_pkg::SEARCH_LAST;
                end
            end
            thmadc_pkg::ST_SEARCH: begin
                if (r_step == '0) begin
                    n_state = thmadc_pkg::ST_SETUP;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            thmadc_pkg::ST_SETUP: begin
                if (i_sts.in_range) begin
                    n_state = thmadc_pkg::ST_DIVIDE;
                    n_step  = thmadc_pkg::DIV_LAST;
                end else begin
                    n_state = thmadc_pkg::ST_DONE;
                end
            end
            thmadc_pkg::ST_DIVIDE: begin
                if (r_step == '0) begin
                    n_state = thmadc_pkg::ST_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            thmadc_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = thmadc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = thmadc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.step = r_step;
        o_in_ready = 1'b0;
        case (r_state)
            thmadc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            thmadc_pkg::ST_SEARCH: o_cmd.search = 1'b1;
            thmadc_pkg::ST_SETUP:  o_cmd.setup  = 1'b1;
            thmadc_pkg::ST_DIVIDE: o_cmd.divide = 1'b1;
            thmadc_pkg::ST_DONE:   o_cmd.finish = i_sts.out_free;
            default: begin
                o_cmd.finish = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/thmadc_dp.sv]
// Datapath: binary table search, span/numerator setup, restoring divider
// and the output register. Depends on thmadc_pkg.
module thmadc_dp #(
    parameter int TABLE_ENTRIES = 21,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  thmadc_pkg::t_dp_cmd                   i_cmd,
    output thmadc_pkg::t_dp_sts                   o_sts,
    input  logic [SAMPLE_BITS-1:0]                i_adc_sample,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [thmadc_pkg::STATUS_W-1:0]       o_status,
    output logic signed [thmadc_pkg::TEMP_W-1:0]  o_temperature_deci
);

    localparam int N_EFF = (TABLE_ENTRIES > thmadc_pkg::BUILTIN_ENTRIES) ?
                           thmadc_pkg::BUILTIN_ENTRIES : TABLE_ENTRIES;
    localparam int CW    = (SAMPLE_BITS > thmadc_pkg::PT_W) ? SAMPLE_BITS : thmadc_pkg::PT_W;
    localparam logic [thmadc_pkg::IDX_W-1:0] N_IDX = thmadc_pkg::IDX_W'(N_EFF);

    logic [SAMPLE_BITS-1:0]                r_sample;
    logic [thmadc_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [thmadc_pkg::DIFF_W-1:0]         r_span;
    logic [thmadc_pkg::NUM_W-1:0]          r_rem, n_rem;
    logic [thmadc_pkg::QUOT_W-1:0]         r_quot, n_quot;
    logic [thmadc_pkg::STATUS_W-1:0]       r_status, n_status;
    logic                                  r_out_valid;
    logic [thmadc_pkg::STATUS_W-1:0]       r_out_status;
    logic signed [thmadc_pkg::TEMP_W-1:0]  r_out_temp;

    logic [thmadc_pkg::IDX_W-1:0]          cand;
    logic [CW-1:0]                         probe_pt, s_ext, hi_pt, lo_pt, diff_w, span_w;
    logic                                  take;
    logic [thmadc_pkg::NUM_W-1:0]          trial;
    logic [thmadc_pkg::NUM_W-1:0]          temp_w;
    logic                                  out_free;

    // Search: grow the index one bit at a time, setting a bit while cand <= N_IDX and entry (cand-1) < sample.
    always_comb begin
        s_ext    = CW'(r_sample);
        cand     = r_idx | (thmadc_pkg::IDX_W'(1) << i_cmd.step);
        probe_pt = CW'(thmadc_pkg::cal_point(cand - 1'b1));
        take     = (cand <= N_IDX) && (probe_pt < s_ext);
        hi_pt    = CW'(thmadc_pkg::cal_point(r_idx));
        lo_pt    = CW'(thmadc_pkg::cal_point(r_idx - 1'b1));
        diff_w   = hi_pt - s_ext;
        span_w   = hi_pt - lo_pt;
        trial    = thmadc_pkg::NUM_W'(r_span) << i_cmd.step;
        temp_w   = thmadc_pkg::NUM_W'(r_idx) * thmadc_pkg::NUM_W'(thmadc_pkg::STEP_DECI)
                 - thmadc_pkg::NUM_W'(r_quot) - thmadc_pkg::NUM_W'(thmadc_pkg::OFFSET_DECI);
    end

    assign o_sts.in_range = (r_idx != '0) && (r_idx != N_IDX);
    assign out_free       = !r_out_valid || i_out_ready;
    assign o_sts.out_free = out_free;

    always_comb begin
        n_idx    = r_idx;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_status = r_status;
        if (i_cmd.load) begin
            n_idx = '0;
        end
        if (i_cmd.search && take) begin
            n_idx = cand;
        end
        if (i_cmd.setup) begin
            n_quot = '0;
            n_rem  = thmadc_pkg::NUM_W'(diff_w[thmadc_pkg::DIFF_W-1:0])
                   * thmadc_pkg::NUM_W'(thmadc_pkg::STEP_DECI);
            if (r_idx == N_IDX) begin
                n_status = thmadc_pkg::STATUS_OVER;
            end else if (r_idx == '0) begin
                n_status = thmadc_pkg::STATUS_UNDER;
            end else begin
                n_status = thmadc_pkg::STATUS_OK;
            end
        end
        // Restoring divide, one quotient bit per cycle, MSB first
        if (i_cmd.divide && (r_rem >= trial)) begin
            n_rem  = r_rem - trial;
            n_quot = r_quot | (thmadc_pkg::QUOT_W'(1) << i_cmd.step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_adc_sample;
        end
        if (i_cmd.setup) begin
            r_span <= span_w[thmadc_pkg::DIFF_W-1:0];
        end
        r_idx    <= n_idx;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_status <= n_status;
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_temp   <= (r_status == thmadc_pkg::STATUS_OK) ?
                            $signed(temp_w[thmadc_pkg::TEMP_W-1:0]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_temperature_deci = r_out_temp;

endmodule

[hw/rtl/thermistor_adc_to_temperature.sv]
// Thermistor ADC sample to temperature (tenths of a degree C).
// Input channel i_adc carries one raw sample per transfer; output channel
// o_temp returns exactly one status/temperature transfer for each sample.
// A sample is located in a 21-point ascending calibration table by a
// binary search, then the fraction within the segment is found by a
// restoring divider that retires one quotient bit per cycle. Out-of-range
// samples skip the divider. One sample is in work at a time.
// Status 1 means at or below the first point, 2 above the last; the
// temperature is then 0.
// The result sits in an output register; the next sample is accepted while
// it waits. A stalled receiver holds the finished work in the controller
// until the output register frees up. Reset clears the controller and the
// output valid; no table clear is needed.
// Depends on thmadc_pkg, thmadc_in_if, thmadc_out_if, thmadc_ctrl, thmadc_dp.
module thermistor_adc_to_temperature #(
    parameter int TABLE_ENTRIES = 21,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thmadc_in_if.sink  i_adc,
    thmadc_out_if.source o_temp
);

    thmadc_pkg::t_dp_cmd cmd;
    thmadc_pkg::t_dp_sts sts;

    thmadc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_adc.valid),
        .o_in_ready (i_adc.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    thmadc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_adc_sample       (i_adc.adc_sample),
        .i_out_ready        (o_temp.ready),
        .o_out_valid        (o_temp.valid),
        .o_status           (o_temp.status),
        .o_temperature_deci (o_temp.temperature_deci)
    );

`ifndef SYNTHESIS
    // Only one sample in work: no accept in the cycle after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adc.valid && i_adc.ready) |=> !i_adc.ready)
        else $error("sample accepted while previous one in work");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_temp.valid && (o_temp.status != thmadc_pkg::STATUS_OK))
            |-> (o_temp.temperature_deci == '0))
        else $error("nonzero temperature with out-of-range status");

    a_temp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_temp.valid && (o_temp.status == thmadc_pkg::STATUS_OK))
            |-> ((o_temp.temperature_deci >= -11'sd150)
                 && (o_temp.temperature_deci <= 11'sd850)))
        else $error("in-range temperature outside table span");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_temp.valid |-> ((o_temp.status == thmadc_pkg::STATUS_OK)
                          || (o_temp.status == thmadc_pkg::STATUS_UNDER)
                          || (o_temp.status == thmadc_pkg::STATUS_OVER)))
        else $error("undefined status code");
`endif

endmodule
